FILE: hw/rtl/ogru_pkg.sv
// shared types and constants for the occupancy grid ray update block
`default_nettype none
package ogru_pkg;
    localparam int GRID_ROWS = 256;
    localparam int GRID_COLS = 256;
    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int AW = RW + CW;

    localparam logic [1:0] OP_RAY   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_SENSOR = 2'd1;
    localparam logic [1:0] ST_HIT    = 2'd2;
    localparam logic [1:0] ST_SAME   = 2'd3;

    localparam logic CFG_OCC  = 1'b0;
    localparam logic CFG_FREE = 1'b1;
    localparam logic [11:0] STEP_RESET = 12'd154;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  status;
        logic [9:0]  sr;
        logic [9:0]  sc;
        logic [9:0]  hr;
        logic [9:0]  hc;
    } t_cmd;
endpackage
`default_nettype wire

FILE: hw/rtl/ogru_front.sv
// front end: centres coordinates, classifies the item, small command queue
`default_nettype none
module ogru_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [1:0]     i_op,
    input  wire logic [7:0]     i_sensor_x,
    input  wire logic [7:0]     i_sensor_y,
    input  wire logic [7:0]     i_hit_x,
    input  wire logic [7:0]     i_hit_y,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_ready,
    output ogru_pkg::t_cmd      o_cmd
);
    import ogru_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       in_fire, out_fire;

    function automatic logic [9:0] ctr(input logic [7:0] v, input int half);
        return 10'($signed({{2{v[7]}}, v}) + 10'(half));
    endfunction

    function automatic logic inside_r(input logic [9:0] v);
        return !v[9] && (v < 10'(GRID_ROWS));
    endfunction

    function automatic logic inside_c(input logic [9:0] v);
        return !v[9] && (v < 10'(GRID_COLS));
    endfunction

    always_comb begin
        n_cmd.op = i_op;
        n_cmd.sr = ctr(i_sensor_x, GRID_ROWS / 2);
        n_cmd.sc = ctr(i_sensor_y, GRID_COLS / 2);
        n_cmd.hr = ctr(i_hit_x, GRID_ROWS / 2);
        n_cmd.hc = ctr(i_hit_y, GRID_COLS / 2);
        n_cmd.status = ST_DONE;
        if (i_op == OP_RAY) begin
            if (!(inside_r(n_cmd.sr) && inside_c(n_cmd.sc))) begin
                n_cmd.status = ST_SENSOR;
            end else if (!(inside_r(n_cmd.hr) && inside_c(n_cmd.hc))) begin
                n_cmd.status = ST_HIT;
            end else if (n_cmd.sr == n_cmd.hr && n_cmd.sc == n_cmd.hc) begin
                n_cmd.status = ST_SAME;
            end
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign in_fire     = i_valid && o_ready;
    assign out_fire    = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (in_fire) begin
                r_wp <= ~r_wp;
            end
            if (out_fire) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(in_fire) - 2'(out_fire);
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ogru_back.sv
// back end: grid memory, bounding box, bresenham walker and result register
`default_nettype none
module ogru_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    input  ogru_pkg::t_cmd      i_cmd,
    input  wire logic [11:0]    i_occ_step,
    input  wire logic [11:0]    i_free_step,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [1:0]          o_status,
    output logic [15:0]         o_cell_log_odds,
    output logic [7:0]          o_box_row_min,
    output logic [7:0]          o_box_row_max,
    output logic [7:0]          o_box_col_min,
    output logic [7:0]          o_box_col_max
);
    import ogru_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_WIPE, S_HIT_RD, S_HIT_WR, S_LN_RD, S_LN_WR, S_RD, S_OUT
    } t_state;

    logic [15:0] r_mem [GRID_ROWS * GRID_COLS];
    logic [15:0] r_rdata;

    t_state      r_state;
    t_cmd        r_cmd;
    logic [RW-1:0] r_rmin, r_rmax;
    logic [CW-1:0] r_cmin, r_cmax;
    logic [AW:0]   r_wipe;
    logic [RW-1:0] r_x;
    logic [CW-1:0] r_y;
    logic [12:0]   r_dx, r_dy;
    logic [13:0]   r_err;
    logic [12:0]   r_k;
    logic          r_sx, r_sy, r_swp;
    logic          r_in_box;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata;
    logic          re;

    logic [RW-1:0] hr;
    logic [CW-1:0] hc;
    assign hr = r_cmd.hr[RW-1:0];
    assign hc = r_cmd.hc[CW-1:0];

    function automatic logic [15:0] sat_add(input logic [15:0] v,
                                            input logic [11:0] s,
                                            input logic neg);
        logic signed [17:0] t;
        t = neg ? 18'($signed(v)) - 18'($signed({6'd0, s}))
                : 18'($signed(v)) + 18'($signed({6'd0, s}));
        if (t > 18'sd32767) begin
            return 16'h7fff;
        end else if (t < -18'sd32768) begin
            return 16'h8000;
        end
        return t[15:0];
    endfunction

    always_comb begin
        re    = 1'b0;
        raddr = {hr, hc};
        we    = 1'b0;
        waddr = {hr, hc};
        wdata = sat_add(r_rdata, i_occ_step, 1'b0);
        unique case (r_state)
            S_IDLE: ;
            S_WIPE: begin
                we    = 1'b1;
                waddr = r_wipe[AW-1:0];
                wdata = '0;
            end
            S_HIT_RD, S_RD: re = 1'b1;
            S_HIT_WR: we = 1'b1;
            S_LN_RD: begin
                re    = 1'b1;
                raddr = {r_x, r_y};
            end
            S_LN_WR: begin
                we    = 1'b1;
                waddr = {r_x, r_y};
                wdata = sat_add(r_rdata, i_free_step, 1'b1);
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
            r_cmd   <= '0;
            r_wipe  <= '0;
            r_rmin  <= RW'(GRID_ROWS / 2);
            r_rmax  <= RW'(GRID_ROWS / 2);
            r_cmin  <= CW'(GRID_COLS / 2);
            r_cmax  <= CW'(GRID_COLS / 2);
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_state <= S_OUT;
                        if (i_cmd.op == OP_RAY && (i_cmd.status == ST_DONE ||
                                                   i_cmd.status == ST_SAME)) begin
                            if (i_cmd.hr[RW-1:0] < r_rmin) r_rmin <= i_cmd.hr[RW-1:0];
                            if (i_cmd.hr[RW-1:0] > r_rmax) r_rmax <= i_cmd.hr[RW-1:0];
                            if (i_cmd.hc[CW-1:0] < r_cmin) r_cmin <= i_cmd.hc[CW-1:0];
                            if (i_cmd.hc[CW-1:0] > r_cmax) r_cmax <= i_cmd.hc[CW-1:0];
                            if (i_cmd.status == ST_DONE) begin
                                r_state <= S_HIT_RD;
                            end
                        end else if (i_cmd.op == OP_READ) begin
                            r_in_box <= !i_cmd.hr[9] && !i_cmd.hc[9] &&
                                i_cmd.hr < 10'(GRID_ROWS) && i_cmd.hc < 10'(GRID_COLS) &&
                                i_cmd.hr >= 10'(r_rmin) && i_cmd.hr <= 10'(r_rmax) &&
                                i_cmd.hc >= 10'(r_cmin) && i_cmd.hc <= 10'(r_cmax);
                            r_state <= S_RD;
                        end else if (i_cmd.op == OP_CLEAR) begin
                            r_wipe  <= '0;
                            r_state <= S_WIPE;
                        end
                    end
                end
                S_WIPE: begin
                    r_wipe <= r_wipe + 1'b1;
                    if (r_wipe == (AW+1)'(GRID_ROWS * GRID_COLS - 1)) begin
                        r_state <= (r_cmd.op == OP_CLEAR) ? S_OUT : S_IDLE;
                    end
                end
                S_HIT_RD: r_state <= S_HIT_WR;
                S_HIT_WR: begin
                    // set up the walk; major axis chosen by the larger delta
                    r_x <= r_cmd.sr[RW-1:0];
                    r_y <= r_cmd.sc[CW-1:0];
                    r_sx <= r_cmd.hr < r_cmd.sr;
                    r_sy <= r_cmd.hc < r_cmd.sc;
                    begin : setup
                        logic [12:0] ax, ay;
                        ax = 13'((r_cmd.hr > r_cmd.sr) ? r_cmd.hr - r_cmd.sr
                                                       : r_cmd.sr - r_cmd.hr);
                        ay = 13'((r_cmd.hc > r_cmd.sc) ? r_cmd.hc - r_cmd.sc
                                                       : r_cmd.sc - r_cmd.hc);
                        r_err <= -14'(ax);
                        if (ay > ax) begin
                            r_dx <= ay; r_dy <= ax; r_swp <= 1'b1;
                        end else begin
                            r_dx <= ax; r_dy <= ay; r_swp <= 1'b0;
                        end
                    end
                    r_k <= 13'd1;
                    r_state <= S_LN_RD;
                end
                S_LN_RD: r_state <= S_LN_WR;
                S_LN_WR: begin : step
                    logic [13:0] e;
                    logic        xs, ys;
                    e  = r_err + {r_dy, 1'b0};
                    xs = !r_swp;
                    ys = r_swp;
                    if (!e[13]) begin
                        e = e - {r_dx, 1'b0};
                        xs = 1'b1;
                        ys = 1'b1;
                    end
                    r_err <= e;
                    // an axis with no travel never moves
                    if (xs && r_cmd.hr != r_cmd.sr) r_x <= r_sx ? r_x - 1'b1 : r_x + 1'b1;
                    if (ys && r_cmd.hc != r_cmd.sc) r_y <= r_sy ? r_y - 1'b1 : r_y + 1'b1;
                    r_k <= r_k + 1'b1;
                    r_state <= (r_k == r_dx) ? S_OUT : S_LN_RD;
                end
                S_RD: r_state <= S_OUT;
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid  <= 1'b1;
                        o_status <= r_cmd.status;
                        o_cell_log_odds <= (r_cmd.op == OP_READ && r_in_box)
                                           ? r_rdata : 16'd0;
                        o_box_row_min <= 8'(r_rmin);
                        o_box_row_max <= 8'(r_rmax);
                        o_box_col_min <= 8'(r_cmin);
                        o_box_col_max <= 8'(r_cmax);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && i_ready && !(r_state == S_OUT)) begin
                o_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/occupancy_grid_ray_update.sv
// top level of the occupancy grid ray update block
// A log-odds grid of 256 x 256 Q8.8 cells with a touched bounding box. After
// reset, and after every clear command, the back end sweeps the grid memory at
// one cell a cycle; meanwhile the front still takes up to two items into its
// queue and then holds ready low. A ray updates its hit cell with a read then a
// write, then walks from the sensor, each cell of the walk being a read then a
// write of the grid memory; a read command passes through a read state, and a
// rejected or same-cell ray goes straight to the result. Items are classified
// and queued in front, two deep, and one result register lets the back end work
// on the next command while a result waits to be taken.
`default_nettype none
module occupancy_grid_ray_update (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_sensor_x,
    input  wire logic [7:0]  i_sensor_y,
    input  wire logic [7:0]  i_hit_x,
    input  wire logic [7:0]  i_hit_y,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_cell_log_odds,
    output logic [7:0]       o_box_row_min,
    output logic [7:0]       o_box_row_max,
    output logic [7:0]       o_box_col_min,
    output logic [7:0]       o_box_col_max,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);
    import ogru_pkg::*;

    logic [11:0] r_occ, r_free;
    logic        cmd_valid, cmd_ready;
    t_cmd        cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= STEP_RESET;
            r_free <= STEP_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_OCC) r_occ <= i_cfg_data;
            if (i_cfg_index == CFG_FREE) r_free <= i_cfg_data;
        end
    end

    ogru_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op, .i_sensor_x, .i_sensor_y,
        .i_hit_x, .i_hit_y,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    ogru_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_cmd(cmd), .i_occ_step(r_occ), .i_free_step(r_free),
        .o_valid, .i_ready, .o_status, .o_cell_log_odds,
        .o_box_row_min, .o_box_row_max, .o_box_col_min, .o_box_col_max
    );
endmodule
`default_nettype wire
